@@ rtl/fcf_pkg.sv @@
// Shared sequencer state codes and control types for the FIR convolution filter.
package fcf_pkg;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam int TAP_INDEX_W = 6;
    localparam int TAPS_CFG_W  = 7;
    localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 7'd64;

    typedef struct packed {
        logic clear;
        logic term_vld;
    } t_mac_ctl;

endpackage

@@ rtl/fcf_ram.sv @@
// Simple dual-port synchronous RAM with registered read.
module fcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fcf_mac.sv @@
// Multiply-accumulate datapath with round-half-up and saturating output.
module fcf_mac #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int NUM_TAPS     = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fcf_pkg::t_mac_ctl       i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_x,
    input  logic [SAMPLE_WIDTH-1:0] i_h,
    output logic                    o_busy,
    output logic [SAMPLE_WIDTH-1:0] o_filtered,
    output logic                    o_saturated
);

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS) + 1;
    localparam int FRAC_W = SAMPLE_WIDTH - 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-PROD_W+1:0]  w_upper;
    logic                     w_fits;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_x) * $signed(i_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.term_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= ROUND_HALF;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign w_upper     = r_acc[ACC_W-1:PROD_W-2];
    assign w_fits      = (&w_upper) || !(|w_upper);
    assign o_busy      = r_prod_vld;
    assign o_saturated = !w_fits;

    always_comb begin
        if (w_fits) begin
            o_filtered = r_acc[PROD_W-2:FRAC_W];
        end else if (r_acc[ACC_W-1]) begin
            o_filtered = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            o_filtered = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

endmodule

@@ rtl/fir_convolution_filter.sv @@
// Direct-form FIR filter: tap sequencer, sample and coefficient memories, output register.
// Each sample runs T = min(taps_in_use, NUM_TAPS) taps, one tap per cycle through the multiplier;
// no new sample or coefficient is taken until the result is loaded into the output register.
// A coefficient transfer yields no result.
// Reset is synchronous, active low: clears control, tap valid bits, history fill count,
// and sets taps_in_use to 64; memory contents are masked, no clearing pass.
module fir_convolution_filter #(
    parameter int NUM_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [fcf_pkg::TAPS_CFG_W-1:0]            i_cfg_wdata,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tap_index, value, zero fill
    input  logic [((fcf_pkg::TAP_INDEX_W+SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // operation, start_of_signal
    input  logic [1:0]                                s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // filtered, zero fill
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // saturated
    output logic [0:0]                                m_axis_tuser
);

    localparam int AW     = $clog2(NUM_TAPS);
    localparam int CW     = $clog2(NUM_TAPS + 1);
    localparam int TW     = (CW > fcf_pkg::TAPS_CFG_W) ? CW : fcf_pkg::TAPS_CFG_W;
    localparam int OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IDX_W  = fcf_pkg::TAP_INDEX_W;

    logic [1:0]                   r_state, n_state;
    logic [fcf_pkg::TAPS_CFG_W-1:0] r_taps;
    logic [NUM_TAPS-1:0]          r_coef_vld;
    logic [AW-1:0]                r_wp, r_rda, r_tap;
    logic [CW-1:0]                r_fill, r_left;
    logic                         r_rd_vld, r_x_ok, r_h_ok;
    logic                         r_out_vld, r_out_sat;
    logic [SAMPLE_WIDTH-1:0]      r_out_data;

    logic                         w_accept, w_op, w_start;
    logic [IDX_W-1:0]             w_index;
    logic [SAMPLE_WIDTH-1:0]      w_value;
    logic                         w_coef_we, w_hist_we;
    logic [TW-1:0]                w_taps_ext;
    logic [CW-1:0]                w_taps;
    logic                         w_issue, w_out_load;
    logic [SAMPLE_WIDTH-1:0]      w_hist_q, w_coef_q, w_x, w_h;
    logic [SAMPLE_WIDTH-1:0]      w_filtered;
    logic                         w_saturated, w_mac_busy;
    fcf_pkg::t_mac_ctl            w_mac_ctl;

    assign w_op    = s_axis_tuser[0];
    assign w_start = s_axis_tuser[1];
    assign w_index = s_axis_tdata[IDX_W-1:0];
    assign w_value = s_axis_tdata[IDX_W+SAMPLE_WIDTH-1:IDX_W];

    assign s_axis_tready = (r_state == fcf_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_coef_we     = w_accept && (w_op == fcf_pkg::OP_COEF) &&
                           (32'(w_index) < NUM_TAPS);
    assign w_hist_we     = w_accept && (w_op == fcf_pkg::OP_SAMPLE);

    assign w_taps_ext = (TW'(r_taps) > TW'(NUM_TAPS)) ? TW'(NUM_TAPS) : TW'(r_taps);
    assign w_taps     = CW'(w_taps_ext);

    assign w_issue    = (r_state == fcf_pkg::ST_RUN);
    assign w_out_load = (r_state == fcf_pkg::ST_DONE) && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= fcf_pkg::TAPS_RESET;
        end else if (i_cfg_we) begin
            r_taps <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fcf_pkg::ST_IDLE: begin
                if (w_hist_we) begin
                    n_state = (w_taps == '0) ? fcf_pkg::ST_DONE : fcf_pkg::ST_RUN;
                end
            end
            fcf_pkg::ST_RUN: begin
                if (r_left == CW'(1)) begin
                    n_state = fcf_pkg::ST_WAIT;
                end
            end
            fcf_pkg::ST_WAIT: begin
                if (!r_rd_vld && !w_mac_busy) begin
                    n_state = fcf_pkg::ST_DONE;
                end
            end
            fcf_pkg::ST_DONE: begin
                if (w_out_load) begin
                    n_state = fcf_pkg::ST_IDLE;
                end
            end
            default: n_state = fcf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fcf_pkg::ST_IDLE;
            r_coef_vld <= '0;
            r_wp       <= '0;
            r_fill     <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;
            if (w_coef_we) begin
                r_coef_vld[AW'(w_index)] <= 1'b1;
            end
            if (w_hist_we) begin
                r_wp <= (r_wp == AW'(NUM_TAPS - 1)) ? '0 : r_wp + AW'(1);
                if (w_start) begin
                    r_fill <= CW'(1);
                end else if (r_fill != CW'(NUM_TAPS)) begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_rda  <= r_wp;
            r_tap  <= '0;
            r_left <= w_taps;
        end else if (w_issue) begin
            r_rda  <= (r_rda == '0) ? AW'(NUM_TAPS - 1) : r_rda - AW'(1);
            r_tap  <= r_tap + AW'(1);
            r_left <= r_left - CW'(1);
        end
        r_x_ok <= (CW'(r_tap) < r_fill);
        r_h_ok <= r_coef_vld[r_tap];
        if (w_out_load) begin
            r_out_data <= w_filtered;
            r_out_sat  <= w_saturated;
        end
    end

    fcf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (NUM_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (r_wp),
        .i_wdata (w_value),
        .i_raddr (r_rda),
        .o_rdata (w_hist_q)
    );

    fcf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (NUM_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (AW'(w_index)),
        .i_wdata (w_value),
        .i_raddr (r_tap),
        .o_rdata (w_coef_q)
    );

    assign w_x = r_x_ok ? w_hist_q : '0;
    assign w_h = r_h_ok ? w_coef_q : '0;

    assign w_mac_ctl.clear    = w_hist_we;
    assign w_mac_ctl.term_vld = r_rd_vld;

    fcf_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .NUM_TAPS     (NUM_TAPS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_mac_ctl),
        .i_x         (w_x),
        .i_h         (w_h),
        .o_busy      (w_mac_busy),
        .o_filtered  (w_filtered),
        .o_saturated (w_saturated)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DW'(r_out_data);
    assign m_axis_tuser  = r_out_sat;

endmodule
